// ===== sv/lfgb_pkg.sv =====
package lfgb_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int TIME_BITS     = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int GAMMA_W       = 16;
  localparam int DIVD_W        = GAMMA_W + TIME_BITS;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

  localparam logic [GAMMA_W-1:0] GAMMA_UNITY = GAMMA_W'(100);
  localparam logic [7:0]         BRIGHT_MAX  = 8'd255;
  localparam logic [IDX_W-1:0]   LAST_ENTRY  = IDX_W'(TABLE_ENTRIES - 1);

  typedef enum logic [2:0] {
    CMD_PIXEL   = 3'd0,
    CMD_TICK    = 3'd1,
    CMD_BSTART  = 3'd2,
    CMD_BTARGET = 3'd3,
    CMD_GSTART  = 3'd4,
    CMD_GTARGET = 3'd5,
    CMD_TWRITE  = 3'd6,
    CMD_CLEAR   = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWEEP,
    S_T_CHK,
    S_T_MUL,
    S_T_GO,
    S_T_WAIT
  } state_t;

  // one classified command waiting for the back end
  typedef struct packed {
    cmd_t                 cmd;
    logic [7:0]           bright;   // saturated brightness
    logic [GAMMA_W-1:0]   gamma;    // raw gamma value
    logic [GAMMA_W-1:0]   gstart;   // gamma value with zero taken as unity
    logic [TIME_BITS-1:0] dur;
    logic [TIME_BITS-1:0] tick;
    logic [IDX_W-1:0]     idx;
    logic [7:0]           data;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 last;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  typedef struct packed {
    logic                 start;
    logic [DIVD_W-1:0]    dividend;
    logic [TIME_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIVD_W-1:0] quot;
    logic              rem_nz;
  } div_rsp_t;

endpackage

// ===== sv/lfgb_front.sv =====
module lfgb_front import lfgb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_value,
  input  logic [31:0] in_duration_ms,
  input  logic [31:0] in_tick_ms,
  input  logic [7:0]  in_lut_index,
  input  logic [7:0]  in_lut_data,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic        in_pixel_last,
  output queue_head_t head,
  input  logic        pop
);

  item_t              q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]    cnt_r;
  logic               push;
  item_t              cls;

  always_comb begin
    cls        = '0;
    cls.cmd    = cmd_t'(in_cmd);
    cls.bright = (in_value > 16'(BRIGHT_MAX)) ? BRIGHT_MAX : in_value[7:0];
    cls.gamma  = in_value;
    cls.gstart = (in_value == '0) ? GAMMA_UNITY : in_value;
    cls.dur    = in_duration_ms[TIME_BITS-1:0];
    cls.tick   = in_tick_ms[TIME_BITS-1:0];
    cls.idx    = in_lut_index[IDX_W-1:0];
    cls.data   = in_lut_data;
    cls.red    = in_red_in;
    cls.green  = in_green_in;
    cls.blue   = in_blue_in;
    cls.last   = in_pixel_last;
  end

  assign in_stall   = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head.valid = (cnt_r != '0);
  assign head.item  = q_mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r <= cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule

// ===== sv/lfgb_div.sv =====
module lfgb_div import lfgb_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic [TIME_BITS-1:0] rem_r, dsr_r;
  logic [DIVD_W-1:0]    quo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r, done_r;
  logic [TIME_BITS:0]   shifted, diff;
  logic                 fits;

  // restoring divide, one quotient bit per cycle
  assign shifted = {rem_r, quo_r[DIVD_W-1]};
  assign diff    = shifted - {1'b0, dsr_r};
  assign fits    = (shifted >= {1'b0, dsr_r});

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[TIME_BITS-1:0] : shifted[TIME_BITS-1:0];
      quo_r <= {quo_r[DIVD_W-2:0], fits};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && !req.start && (cnt_r == CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  assign rsp.busy   = busy_r;
  assign rsp.done   = done_r;
  assign rsp.quot   = quo_r;
  assign rsp.rem_nz = (rem_r != '0);

endmodule

// ===== sv/lfgb_back.sv =====
module lfgb_back import lfgb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  queue_head_t  head,
  output logic         pop,
  output div_req_t     div_req,
  input  div_rsp_t     div_rsp,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_red_out,
  output logic [7:0]   out_green_out,
  output logic [7:0]   out_blue_out,
  output logic         out_last_out,
  output logic [7:0]   out_brightness_now,
  output logic [15:0]  out_gamma_now,
  output logic         out_table_stale
);

  state_t state_r, state_nxt;
  item_t  cur_r;
  logic   sel_r;  // 0 brightness fade, 1 gamma fade

  logic                 b_on_r, g_on_r, stale_r;
  logic [7:0]           b_cur_r, b_from_r, b_to_r;
  logic [GAMMA_W-1:0]   g_cur_r, g_from_r, g_to_r;
  logic [TIME_BITS-1:0] b_el_r, b_span_r, g_el_r, g_span_r;

  logic [TIME_BITS-1:0] t_r;
  logic [DIVD_W-1:0]    mag_r;
  logic                 neg_r;
  logic [IDX_W-1:0]     sweep_r;

  logic [7:0] lut_r [TABLE_ENTRIES];
  logic [7:0] lut_g [TABLE_ENTRIES];
  logic [7:0] lut_b [TABLE_ENTRIES];
  logic [7:0] rd_r, rd_g, rd_b;

  logic                 out_valid_r, out_free, emit;
  logic                 t_on, t_reach, t_direct;
  logic [GAMMA_W-1:0]   t_from, t_to, t_abs, set_val, fade_v;
  logic [TIME_BITS-1:0] t_el, t_span, t_sat;
  logic [TIME_BITS:0]   t_sum;
  logic                 set_en, fade_clr, fade_step;
  logic                 b_start, b_fade, g_start, g_fade, clr, lut_we;
  logic [IDX_W-1:0]     lut_addr;
  logic [7:0]           lut_din;
  logic [7:0]           b_now;
  logic [GAMMA_W-1:0]   g_now;
  logic                 st_now;

  function automatic logic [7:0] shade(input logic [7:0] raw, input logic [7:0] lut,
                                       input logic g_on, input logic b_on,
                                       input logic [7:0] br);
    logic [7:0]  c;
    logic [15:0] p;
    c = g_on ? lut : raw;
    p = c * br;
    return b_on ? p[15:8] : c;
  endfunction

  // fade arithmetic shared by both channels
  always_comb begin
    t_on   = sel_r ? g_on_r : b_on_r;
    t_from = sel_r ? g_from_r : {8'b0, b_from_r};
    t_to   = sel_r ? g_to_r : {8'b0, b_to_r};
    t_el   = sel_r ? g_el_r : b_el_r;
    t_span = sel_r ? g_span_r : b_span_r;
    t_sum  = {1'b0, t_el} + {1'b0, cur_r.tick};
    t_sat  = t_sum[TIME_BITS] ? '1 : t_sum[TIME_BITS-1:0];
    t_reach  = (t_sat >= t_span);
    t_direct = t_on && ((t_span == '0) || t_reach);
    t_abs  = (t_to < t_from) ? (t_from - t_to) : (t_to - t_from);
    // gamma rounds toward minus infinity, brightness toward zero
    fade_v = neg_r ? (t_from - div_rsp.quot[GAMMA_W-1:0]
                      - GAMMA_W'(sel_r && div_rsp.rem_nz))
                   : (t_from + div_rsp.quot[GAMMA_W-1:0]);
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    emit      = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = mag_r;
    div_req.divisor  = t_span;
    set_en    = 1'b0;
    set_val   = t_to;
    fade_clr  = 1'b0;
    fade_step = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.item.cmd)
            CMD_TICK:  state_nxt = S_T_CHK;
            CMD_CLEAR: state_nxt = S_SWEEP;
            default:   state_nxt = S_EXEC;
          endcase
        end
      end
      S_SWEEP: begin
        if (sweep_r == LAST_ENTRY) state_nxt = S_EXEC;
      end
      S_T_CHK: begin
        if (!t_on || t_direct) begin
          set_en    = t_direct;
          fade_clr  = t_on && (t_span != '0);
          state_nxt = sel_r ? S_EXEC : S_T_CHK;
        end else begin
          state_nxt = S_T_MUL;
        end
      end
      S_T_MUL: state_nxt = S_T_GO;
      S_T_GO: begin
        div_req.start = 1'b1;
        state_nxt     = S_T_WAIT;
      end
      S_T_WAIT: begin
        if (div_rsp.done) begin
          set_en    = 1'b1;
          set_val   = fade_v;
          fade_step = 1'b1;
          state_nxt = sel_r ? S_EXEC : S_T_CHK;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign b_start = emit && ((cur_r.cmd == CMD_BSTART) || (cur_r.cmd == CMD_BTARGET && !b_on_r));
  assign b_fade  = emit && (cur_r.cmd == CMD_BTARGET) && b_on_r;
  assign g_start = emit && ((cur_r.cmd == CMD_GSTART) || (cur_r.cmd == CMD_GTARGET && !g_on_r));
  assign g_fade  = emit && (cur_r.cmd == CMD_GTARGET) && g_on_r;
  assign clr     = emit && (cur_r.cmd == CMD_CLEAR);

  always_ff @(posedge clk) begin
    if (pop) cur_r <= head.item;
    if (state_r == S_T_CHK) t_r <= t_sat;
    if (state_r == S_T_MUL) begin
      neg_r <= (t_to < t_from);
      mag_r <= t_abs * t_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r   <= 1'b0;
      sweep_r <= '0;
    end else begin
      if (pop) sel_r <= 1'b0;
      else if ((state_r == S_T_CHK && state_nxt != S_T_MUL) ||
               (state_r == S_T_WAIT && div_rsp.done)) sel_r <= 1'b1;
      if (state_r == S_SWEEP) sweep_r <= sweep_r + 1'b1;
      else                    sweep_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      b_on_r <= 1'b0; b_cur_r <= '0; b_from_r <= '0; b_to_r <= '0;
      b_el_r <= '0;   b_span_r <= '0;
      g_on_r <= 1'b0; g_cur_r <= '0; g_from_r <= '0; g_to_r <= '0;
      g_el_r <= '0;   g_span_r <= '0;
      stale_r <= 1'b0;
    end else begin
      if (b_start) begin
        b_on_r <= 1'b1; b_cur_r <= cur_r.bright; b_from_r <= cur_r.bright;
        b_to_r <= cur_r.bright; b_el_r <= '0; b_span_r <= '0;
      end else if (b_fade) begin
        b_from_r <= b_cur_r; b_to_r <= cur_r.bright; b_el_r <= '0; b_span_r <= cur_r.dur;
      end
      if (g_start) begin
        g_on_r <= 1'b1; g_cur_r <= cur_r.gstart; g_from_r <= cur_r.gstart;
        g_to_r <= cur_r.gstart; g_el_r <= '0; g_span_r <= '0;
        stale_r <= 1'b1;
      end else if (g_fade) begin
        g_from_r <= g_cur_r; g_to_r <= cur_r.gamma; g_el_r <= '0; g_span_r <= cur_r.dur;
      end
      if (emit && cur_r.cmd == CMD_TWRITE && cur_r.idx == LAST_ENTRY) stale_r <= 1'b0;
      // tick results
      if (set_en) begin
        if (sel_r) begin
          if (set_val != g_cur_r) begin
            g_cur_r <= set_val;
            stale_r <= 1'b1;
          end
        end else begin
          b_cur_r <= set_val[7:0];
        end
      end
      if (fade_clr) begin
        if (sel_r) begin g_el_r <= '0; g_span_r <= '0; end
        else       begin b_el_r <= '0; b_span_r <= '0; end
      end
      if (fade_step) begin
        if (sel_r) g_el_r <= t_r;
        else       b_el_r <= t_r;
      end
    end
  end

  // three copies of the table give one read port per color
  assign lut_we   = (state_r == S_SWEEP) || (emit && cur_r.cmd == CMD_TWRITE);
  assign lut_addr = (state_r == S_SWEEP) ? sweep_r : cur_r.idx;
  assign lut_din  = (state_r == S_SWEEP) ? 8'd0 : cur_r.data;

  always_ff @(posedge clk) begin
    if (lut_we) begin
      lut_r[lut_addr] <= lut_din;
      lut_g[lut_addr] <= lut_din;
      lut_b[lut_addr] <= lut_din;
    end
    if (pop) begin
      rd_r <= lut_r[head.item.red];
      rd_g <= lut_g[head.item.green];
      rd_b <= lut_b[head.item.blue];
    end
  end

  // status as it stands after the command in S_EXEC
  always_comb begin
    b_now  = b_cur_r;
    g_now  = g_cur_r;
    st_now = stale_r;
    case (cur_r.cmd)
      CMD_BSTART:  b_now = cur_r.bright;
      CMD_BTARGET: b_now = b_on_r ? b_cur_r : cur_r.bright;
      CMD_GSTART: begin
        g_now  = cur_r.gstart;
        st_now = 1'b1;
      end
      CMD_GTARGET: begin
        g_now  = g_on_r ? g_cur_r : cur_r.gstart;
        st_now = g_on_r ? stale_r : 1'b1;
      end
      CMD_TWRITE: st_now = (cur_r.idx == LAST_ENTRY) ? 1'b0 : stale_r;
      CMD_CLEAR: begin
        b_now  = '0;
        g_now  = '0;
        st_now = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      if (cur_r.cmd == CMD_PIXEL) begin
        out_red_out   <= shade(cur_r.red, rd_r, g_on_r, b_on_r, b_cur_r);
        out_green_out <= shade(cur_r.green, rd_g, g_on_r, b_on_r, b_cur_r);
        out_blue_out  <= shade(cur_r.blue, rd_b, g_on_r, b_on_r, b_cur_r);
        out_last_out  <= cur_r.last;
      end else begin
        out_red_out   <= '0;
        out_green_out <= '0;
        out_blue_out  <= '0;
        out_last_out  <= 1'b0;
      end
      out_brightness_now <= b_now;
      out_gamma_now      <= g_now;
      out_table_stale    <= st_now;
    end
  end

  assign out_valid = out_valid_r;

  a_b_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !b_on_r |-> (b_cur_r == '0 && b_span_r == '0))
    else $error("brightness state set while inactive");
  a_g_off_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !g_on_r |-> (g_cur_r == '0 && !stale_r))
    else $error("gamma state set while inactive");
  a_b_el_range: assert property (@(posedge clk) disable iff (!rst_n)
    (b_span_r == '0) ? (b_el_r == '0) : (b_el_r < b_span_r))
    else $error("brightness elapsed out of range");
  a_g_el_range: assert property (@(posedge clk) disable iff (!rst_n)
    (g_span_r == '0) ? (g_el_r == '0) : (g_el_r < g_span_r))
    else $error("gamma elapsed out of range");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (div_rsp.done || div_rsp.busy) |-> state_r == S_T_WAIT)
    else $error("divider active outside fade wait");

endmodule

// ===== sv/led_fade_gamma_brightness.sv =====
// LED pixel post-processor: gamma table, brightness scale, linear fades.
//
// Input channel (in_*): one command per beat, accepted when in_valid is
// high and in_stall low. Pixels, ticks, fade starts and targets, gamma
// table writes and clear all share it. Output channel (out_*): exactly one
// result beat per command, in order, taken when out_valid && !out_stall.
//
// A two-entry queue sits between the front (accept and classify) and the
// back (table, fade state, sequencer), so input keeps flowing while the
// back end is busy or the output is stalled.
//
// Flow: pixel, start, target and table write are popped in S_IDLE and
// emitted from S_EXEC into the registered output; the back end takes
// one command at a time. A tick runs both fades, brightness then gamma,
// through one shared restoring divider; a fade in motion adds a multiply
// and a divide (48 divide steps). Clear sweeps the table to zero.
//
// Reset (rst_n low, synchronous) clears fade state and the stale flag but
// not the gamma table. A stalled output holds its beat; the back end then
// waits, and once the queue fills, in_stall rises.
module led_fade_gamma_brightness import lfgb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [15:0] in_value,
  input  logic [31:0] in_duration_ms,
  input  logic [31:0] in_tick_ms,
  input  logic [7:0]  in_lut_index,
  input  logic [7:0]  in_lut_data,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic        in_pixel_last,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_last_out,
  output logic [7:0]  out_brightness_now,
  output logic [15:0] out_gamma_now,
  output logic        out_table_stale
);

  queue_head_t head;
  logic        pop;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  lfgb_front u_front (
    .clk, .rst_n,
    .in_valid, .in_stall, .in_cmd, .in_value, .in_duration_ms, .in_tick_ms,
    .in_lut_index, .in_lut_data, .in_red_in, .in_green_in, .in_blue_in,
    .in_pixel_last,
    .head, .pop
  );

  lfgb_div u_div (
    .clk, .rst_n,
    .req (div_req),
    .rsp (div_rsp)
  );

  lfgb_back u_back (
    .clk, .rst_n,
    .head, .pop, .div_req, .div_rsp,
    .out_valid, .out_stall, .out_red_out, .out_green_out, .out_blue_out,
    .out_last_out, .out_brightness_now, .out_gamma_now, .out_table_stale
  );

endmodule
